[hw/rtl/ldbq_pkg.sv]
// Shared types and constants for the log-degree bucket queue.
package ldbq_pkg;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_GET_MAX = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_CLAMP = 2'd3;

  localparam logic [1:0] REG_DEGREE_BASE = 2'd0;
  localparam logic [1:0] REG_LOG_SCALE = 2'd1;
  localparam logic [1:0] REG_BUCKET_OFFSET = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOG,
    S_MUL,
    S_CLASSIFY,
    S_LOOKUP,
    S_DECIDE,
    S_TAKE_READ,
    S_TAKE_WRITE,
    S_CLEAR_EDGE,
    S_PLACE,
    S_MAX_READ,
    S_MAX_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } log_ctrl_t;

endpackage

[hw/rtl/ldbq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ldbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ldbq_log2.sv]
// Iterative fixed-point log2 by repeated squaring, one fraction bit per cycle.
module ldbq_log2 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ldbq_pkg::log_ctrl_t       ctrl_in,
  input  logic [15:0]               degree,
  output logic                      done,
  output logic [4+FRAC_BITS-1:0]    log_value
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [31:0] x;
  logic [3:0] n;
  logic [FRAC_BITS-1:0] frac;
  logic [CW-1:0] count;
  logic busy;
  logic [63:0] sq;
  logic [32:0] sq_t;
  logic [3:0] msb;

  always_comb begin
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (degree[i]) begin
        msb = 4'(i);
      end
    end
  end

  assign sq = 64'(x) * 64'(x);
  assign sq_t = sq[62:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl_in.start) begin
        busy <= 1'b1;
        n <= msb;
        x <= 32'(({16'd0, degree} << (5'd30 - 5'(msb))));
        count <= '0;
        frac <= '0;
      end else if (busy) begin
        if (sq_t[31]) begin
          x <= sq_t[32:1];
          frac <= {frac[FRAC_BITS-2:0], 1'b1};
        end else begin
          x <= sq_t[31:0];
          frac <= {frac[FRAC_BITS-2:0], 1'b0};
        end
        if (count == CW'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        count <= count + 1'b1;
      end
    end
  end

  assign log_value = {n, frac};

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("log done held");

  property p_no_restart;
    @(posedge clk) disable iff (rst) busy |-> !ctrl_in.start;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("log restarted");

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("stray done");

endmodule

[hw/rtl/log_degree_bucket_queue.sv]
// Top level of the log-degree bucket queue: register port, sequencer and memories.
// After reset, busy stays high while the edge table is cleared. One command is taken at a
// time while busy is low; its result word appears with a one-cycle strobe on done, and the
// next command can be taken in that strobe cycle. An add or update runs through the serial
// log2 unit (one fraction bit per cycle) and the dependent reads and writes of the edge and
// bucket memories; a remove or get-maximum does not use the log2 unit. Results cannot be
// stalled.
module log_degree_bucket_queue #(
  parameter int NUM_BUCKETS = 32,
  parameter int MAX_EDGES = 1024,
  parameter int BUCKET_CAP = 1024,
  parameter int LOG_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [9:0]  edge_id,
  input  logic [15:0] degree,
  output logic        done,
  output logic [9:0]  result_edge,
  output logic [4:0]  result_bucket,
  output logic [9:0]  result_position,
  output logic [1:0]  status
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int SW = $clog2(BUCKET_CAP);
  localparam int CNTW = SW + 1;
  localparam int LW = 4 + LOG_FRAC_BITS;
  localparam int PW = LW + 21;

  logic [13:0] degree_base;
  logic [20:0] log_scale;
  logic [5:0] bucket_offset;

  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_base <= 14'd1;
      log_scale <= 21'd65536;
      bucket_offset <= 6'd0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        ldbq_pkg::REG_DEGREE_BASE: degree_base <= pwdata[13:0];
        ldbq_pkg::REG_LOG_SCALE: log_scale <= pwdata[20:0];
        ldbq_pkg::REG_BUCKET_OFFSET: bucket_offset <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ldbq_pkg::REG_DEGREE_BASE: prdata = {18'd0, degree_base};
      ldbq_pkg::REG_LOG_SCALE: prdata = {11'd0, log_scale};
      ldbq_pkg::REG_BUCKET_OFFSET: prdata = {26'd0, bucket_offset};
      default: prdata = 32'd0;
    endcase
  end

  ldbq_pkg::state_t state, state_next;

  logic [1:0] r_cmd;
  logic [9:0] r_edge;
  logic [15:0] r_degree;
  logic [BW-1:0] j;
  logic clamped;
  logic [PW-1:0] prod;
  logic [CNTW-1:0] bucket_count [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] nonempty_map;
  logic [EW-1:0] init_addr;
  logic [BW-1:0] old_b;
  logic [SW-1:0] old_s;
  logic [BW-1:0] top;
  logic [BW-1:0] top_next;

  ldbq_pkg::log_ctrl_t log_ctrl;
  logic log_done;
  logic [LW-1:0] log_value;

  ldbq_log2 #(.FRAC_BITS(LOG_FRAC_BITS)) u_log2 (
    .clk(clk), .rst(rst), .ctrl_in(log_ctrl), .degree(degree),
    .done(log_done), .log_value(log_value)
  );

  logic eb_we;
  logic [EW-1:0] eb_waddr, eb_raddr;
  logic [BW+SW:0] eb_wdata, eb_rdata;

  ldbq_ram #(.WIDTH(BW + SW + 1), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(eb_we), .waddr(eb_waddr), .wdata(eb_wdata),
    .raddr(eb_raddr), .rdata(eb_rdata)
  );

  logic bs_we;
  logic [BW+SW-1:0] bs_waddr, bs_raddr;
  logic [EW-1:0] bs_wdata, bs_rdata;

  ldbq_ram #(.WIDTH(EW), .DEPTH(NUM_BUCKETS * BUCKET_CAP)) u_store_ram (
    .clk(clk), .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata),
    .raddr(bs_raddr), .rdata(bs_rdata)
  );

  logic accept;
  logic edge_ok;
  logic present;
  logic [CNTW-1:0] old_last;
  logic [CNTW-1:0] cnt_j;
  logic [PW-LOG_FRAC_BITS-17:0] v;
  logic [PW-LOG_FRAC_BITS-17:0] vsub;

  assign accept = start && !busy;
  assign busy = (state != ldbq_pkg::S_IDLE);
  assign edge_ok = ({7'd0, r_edge} < 17'(MAX_EDGES));
  assign present = eb_rdata[BW+SW];
  assign old_last = bucket_count[old_b] - 1'b1;
  assign cnt_j = bucket_count[j];
  assign v = prod[PW-1:LOG_FRAC_BITS+16];
  assign vsub = v - (PW-LOG_FRAC_BITS-16)'(bucket_offset);

  always_comb begin
    top_next = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (nonempty_map[i]) begin
        top_next = BW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ldbq_pkg::S_INIT: begin
        if (init_addr == EW'(MAX_EDGES - 1)) begin
          state_next = ldbq_pkg::S_IDLE;
        end
      end
      ldbq_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ldbq_pkg::S_LOG;
        end
      end
      ldbq_pkg::S_LOG: begin
        if (r_cmd == ldbq_pkg::CMD_GET_MAX) begin
          state_next = (nonempty_map == '0) ? ldbq_pkg::S_DONE : ldbq_pkg::S_MAX_READ;
        end else if (!edge_ok) begin
          state_next = ldbq_pkg::S_DONE;
        end else if (r_cmd == ldbq_pkg::CMD_REMOVE) begin
          state_next = ldbq_pkg::S_LOOKUP;
        end else if (log_done) begin
          state_next = ldbq_pkg::S_MUL;
        end
      end
      ldbq_pkg::S_MUL: state_next = ldbq_pkg::S_CLASSIFY;
      ldbq_pkg::S_CLASSIFY: state_next = ldbq_pkg::S_LOOKUP;
      ldbq_pkg::S_LOOKUP: state_next = ldbq_pkg::S_DECIDE;
      ldbq_pkg::S_DECIDE: begin
        if (r_cmd == ldbq_pkg::CMD_REMOVE) begin
          state_next = present ? ldbq_pkg::S_TAKE_READ : ldbq_pkg::S_DONE;
        end else if (present && eb_rdata[BW+SW-1:SW] == j) begin
          state_next = ldbq_pkg::S_DONE;
        end else if (cnt_j >= CNTW'(BUCKET_CAP)) begin
          state_next = ldbq_pkg::S_DONE;
        end else if (present) begin
          state_next = ldbq_pkg::S_TAKE_READ;
        end else begin
          state_next = ldbq_pkg::S_PLACE;
        end
      end
      ldbq_pkg::S_TAKE_READ: state_next = ldbq_pkg::S_TAKE_WRITE;
      ldbq_pkg::S_TAKE_WRITE: begin
        state_next = (r_cmd == ldbq_pkg::CMD_REMOVE) ? ldbq_pkg::S_CLEAR_EDGE
                                                     : ldbq_pkg::S_PLACE;
      end
      ldbq_pkg::S_CLEAR_EDGE: state_next = ldbq_pkg::S_DONE;
      ldbq_pkg::S_PLACE: state_next = ldbq_pkg::S_DONE;
      ldbq_pkg::S_MAX_READ: state_next = ldbq_pkg::S_MAX_WAIT;
      ldbq_pkg::S_MAX_WAIT: state_next = ldbq_pkg::S_DONE;
      ldbq_pkg::S_DONE: state_next = ldbq_pkg::S_IDLE;
      default: state_next = ldbq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    log_ctrl.start = 1'b0;
    log_ctrl.done = 1'b0;
    eb_we = 1'b0;
    eb_waddr = EW'(r_edge);
    eb_wdata = {1'b1, j, cnt_j[SW-1:0]};
    eb_raddr = EW'(r_edge);
    bs_we = 1'b0;
    bs_waddr = {j, cnt_j[SW-1:0]};
    bs_wdata = EW'(r_edge);
    bs_raddr = {old_b, old_last[SW-1:0]};
    case (state)
      ldbq_pkg::S_INIT: begin
        eb_we = 1'b1;
        eb_waddr = init_addr;
        eb_wdata = '0;
      end
      ldbq_pkg::S_IDLE: log_ctrl.start = accept && cmd != ldbq_pkg::CMD_REMOVE
                                         && cmd != ldbq_pkg::CMD_GET_MAX;
      ldbq_pkg::S_LOG: log_ctrl.done = log_done;
      ldbq_pkg::S_TAKE_WRITE: begin
        bs_we = 1'b1;
        bs_waddr = {old_b, old_s};
        bs_wdata = bs_rdata;
        eb_we = 1'b1;
        eb_waddr = bs_rdata;
        eb_wdata = {1'b1, old_b, old_s};
      end
      ldbq_pkg::S_CLEAR_EDGE: begin
        eb_we = 1'b1;
        eb_wdata = '0;
      end
      ldbq_pkg::S_PLACE: begin
        bs_we = 1'b1;
        eb_we = 1'b1;
      end
      ldbq_pkg::S_MAX_READ: bs_raddr = {top, {SW{1'b0}}};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldbq_pkg::S_INIT;
      init_addr <= '0;
      done <= 1'b0;
      nonempty_map <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bucket_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      done <= 1'b0;
      case (state)
        ldbq_pkg::S_INIT: init_addr <= init_addr + 1'b1;
        ldbq_pkg::S_IDLE: begin
          if (accept) begin
            r_cmd <= cmd;
            r_edge <= edge_id;
            r_degree <= degree;
            j <= '0;
            clamped <= 1'b0;
            top <= top_next;
            result_edge <= edge_id;
            result_bucket <= 5'd0;
            result_position <= 10'd0;
            status <= ldbq_pkg::ST_EMPTY;
          end
        end
        ldbq_pkg::S_LOG: begin
          if (r_cmd == ldbq_pkg::CMD_GET_MAX) begin
            result_edge <= 10'd0;
          end
        end
        ldbq_pkg::S_MUL: prod <= PW'(log_value) * PW'(log_scale);
        ldbq_pkg::S_CLASSIFY: begin
          if (r_degree != 16'd0 && {2'd0, r_degree} >= {2'd0, degree_base, 2'd0}
              && v > (PW-LOG_FRAC_BITS-16)'(bucket_offset)) begin
            if (vsub >= (PW-LOG_FRAC_BITS-16)'(NUM_BUCKETS)) begin
              j <= BW'(NUM_BUCKETS - 1);
              clamped <= 1'b1;
            end else begin
              j <= vsub[BW-1:0];
            end
          end
        end
        ldbq_pkg::S_DECIDE: begin
          old_b <= eb_rdata[BW+SW-1:SW];
          old_s <= eb_rdata[SW-1:0];
          if (r_cmd == ldbq_pkg::CMD_REMOVE) begin
            if (present) begin
              result_bucket <= 5'(eb_rdata[BW+SW-1:SW]);
              result_position <= 10'(eb_rdata[SW-1:0]);
              status <= ldbq_pkg::ST_OK;
            end
          end else begin
            result_bucket <= 5'(j);
            if (present && eb_rdata[BW+SW-1:SW] == j) begin
              result_position <= 10'(eb_rdata[SW-1:0]);
              status <= clamped ? ldbq_pkg::ST_CLAMP : ldbq_pkg::ST_OK;
            end else if (cnt_j >= CNTW'(BUCKET_CAP)) begin
              status <= ldbq_pkg::ST_FULL;
            end else begin
              status <= clamped ? ldbq_pkg::ST_CLAMP : ldbq_pkg::ST_OK;
            end
          end
        end
        ldbq_pkg::S_TAKE_WRITE: begin
          bucket_count[old_b] <= old_last;
          if (old_last == '0) begin
            nonempty_map[old_b] <= 1'b0;
          end
        end
        ldbq_pkg::S_PLACE: begin
          result_position <= 10'(cnt_j);
          bucket_count[j] <= cnt_j + 1'b1;
          nonempty_map[j] <= 1'b1;
        end
        ldbq_pkg::S_MAX_WAIT: begin
          result_edge <= 10'(bs_rdata);
          result_bucket <= 5'(top);
          status <= ldbq_pkg::ST_OK;
        end
        ldbq_pkg::S_DONE: done <= 1'b1;
        default: ;
      endcase
    end
  end

  property p_one_result;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_one_result: assert property (p_one_result) else $error("double result");

  property p_busy_until_done;
    @(posedge clk) disable iff (rst) accept |=> busy;
  endproperty
  a_busy_until_done: assert property (p_busy_until_done) else $error("not busy");

  property p_place_sets_map;
    @(posedge clk) disable iff (rst) state == ldbq_pkg::S_PLACE |=> nonempty_map != '0;
  endproperty
  a_place_sets_map: assert property (p_place_sets_map) else $error("map not set");

endmodule
